/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module of this project.
// Depends on nothing; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge and ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked at every rising edge, reset cycles included.
`define ASSERT_CLK_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* rtl/core/bbp_pkg.sv */
// Package of the bimodal branch predictor: field widths, defaults,
// and the command and status bundles between controller and datapath.
// Depends on nothing.
`default_nettype none

package bbp_pkg;

    // Field widths fixed by the stream format.
    localparam int ADDR_W      = 64;
    localparam int CTR_OUT_W   = 2;
    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 8;

    // The address is folded as digits of CHUNK_W bits each.
    localparam int CHUNK_W     = 16;
    localparam int CHUNKS      = ADDR_W / CHUNK_W;
    // Growth of the folded sum over the modulus width.
    localparam int FOLD_GROW_W = CHUNK_W + $clog2(CHUNKS);

    // Default geometry of the counter table.
    localparam int DEF_TABLE_DEPTH   = 16384;
    localparam int DEF_INDEX_MODULUS = 16381;
    localparam int DEF_COUNTER_WIDTH = 2;

    // Transaction kinds carried on s_tuser.
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;   // write zero at the clearing address and advance it
        logic load_item;  // capture the input transaction and its folded address
        logic quot_en;    // register the quotient estimate
        logic sub_en;     // register the value minus quotient times modulus
        logic fix_en;     // final correction, register the remainder
        logic wrap_load;  // restart the reduction on the remainder for the table wrap
        logic rd_en;      // read the counter at the index
        logic finish;     // load the result register; for an update, also write the new counter
    } bbp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // clearing address is at the last entry
        logic wrap_due;    // modulus exceeds table depth and the wrap is still to do
        logic out_free;    // result register can take a new result this cycle
    } bbp_status_t;

endpackage

`default_nettype wire

/* rtl/core/bbp_digit_reduce.sv */
// Folding stage of the index unit: scales each address digit by its place value
// modulo the index modulus and sums the terms. Uses ADDR_W, CHUNK_W and CHUNKS from bbp_pkg.
`default_nettype none

module bbp_digit_reduce
    import bbp_pkg::*;
#(
    parameter int MODULUS = DEF_INDEX_MODULUS,
    parameter int SUM_W   = 32
) (
    input  wire logic [ADDR_W-1:0] addr,
    output logic      [SUM_W-1:0]  sum
);

    logic [SUM_W-1:0] term [CHUNKS];

    // Each digit times the constant weight of its position, the weight taken modulo the modulus.
    for (genvar k = 0; k < CHUNKS; k++) begin : g_digit
        localparam logic [SUM_W-1:0] WEIGHT =
            SUM_W'((64'd1 << (CHUNK_W * k)) % 64'(MODULUS));
        assign term[k] = SUM_W'(addr[k*CHUNK_W +: CHUNK_W]) * WEIGHT;
    end

    // The sum is congruent to the address and stays below 2^FOLD_GROW_W times the modulus.
    always_comb begin
        sum = '0;
        for (int k = 0; k < CHUNKS; k++) begin
            sum = sum + term[k];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bbp_ctrl.sv */
// Controller of the bimodal branch predictor: sequences the clearing pass,
// the index computation, the table read and the counter update.
// Depends on bbp_pkg.
`default_nettype none

module bbp_ctrl
    import bbp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire bbp_status_t status,
    output bbp_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_QUOT   = 7'b0000100,
        ST_SUB    = 7'b0001000,
        ST_FIX    = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass over the table.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_QUOT;
                end
            end
            ST_QUOT: begin
                cmd.quot_en = 1'b1;
                state_next  = ST_SUB;
            end
            ST_SUB: begin
                cmd.sub_en = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix_en = 1'b1;
                // A second pass wraps the remainder into the table.
                if (status.wrap_due) begin
                    cmd.wrap_load = 1'b1;
                    state_next    = ST_QUOT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // Hold until the result register has room.
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/bbp_datapath.sv */
// Datapath of the bimodal branch predictor: item registers, the index unit,
// the counter memory and the result register.
// Depends on bbp_pkg and bbp_digit_reduce.
`default_nettype none

module bbp_datapath
    import bbp_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int INDEX_MODULUS = DEF_INDEX_MODULUS,
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire bbp_cmd_t             cmd,
    output bbp_status_t               status
);

    localparam int TBL_AW     = $clog2(TABLE_DEPTH);
    localparam int MAX_MOD    = (INDEX_MODULUS > TABLE_DEPTH) ? INDEX_MODULUS : TABLE_DEPTH;
    localparam int REM_W      = $clog2(MAX_MOD) + 1;
    localparam int MOD_AW     = $clog2(INDEX_MODULUS);
    localparam int SUM_W      = MOD_AW + FOLD_GROW_W;
    localparam int MU_W       = (MOD_AW > FOLD_GROW_W + 1) ? MOD_AW : FOLD_GROW_W + 1;
    localparam int PROD_W     = SUM_W + MU_W;
    localparam bit NEED_FOLD  = INDEX_MODULUS > TABLE_DEPTH;
    localparam int EXT_W      = (COUNTER_WIDTH > CTR_OUT_W) ? COUNTER_WIDTH : CTR_OUT_W;

    // Reciprocals for the quotient estimate: the first pass reduces a value
    // below 2^SUM_W by the index modulus, the wrap pass a value below
    // 2^MOD_AW by the table depth.
    localparam logic [MU_W-1:0] MU_INDEX = MU_W'((64'd1 << SUM_W) / 64'(INDEX_MODULUS));
    localparam logic [MU_W-1:0] MU_TABLE = MU_W'((64'd1 << MOD_AW) / 64'(TABLE_DEPTH));

    localparam logic [COUNTER_WIDTH-1:0] CTR_MAX = '1;

    // Counter memory.
    logic [COUNTER_WIDTH-1:0] mem [TABLE_DEPTH];

    // Control registers.
    logic              mod_sel_reg;
    logic              mod_sel_next;
    logic [TBL_AW-1:0] clr_addr_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    // Payload registers.
    logic                     cmd_reg;
    logic                     taken_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [MU_W-1:0]          quot_reg;
    logic [REM_W-1:0]         diff_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [COUNTER_WIDTH-1:0] rd_data_reg;
    logic                     out_pred_reg;
    logic [CTR_OUT_W-1:0]     out_ctr_reg;

    logic [SUM_W-1:0]         fold_sum;
    logic [REM_W-1:0]         modulus;
    logic [MU_W-1:0]          mu;
    logic [PROD_W-1:0]        quot_prod;
    logic [MU_W-1:0]          quot_est;
    logic [SUM_W-1:0]         quot_mul;
    logic [SUM_W-1:0]         diff_full;
    logic [REM_W-1:0]         rem_fixed;
    logic [TBL_AW-1:0]        tbl_idx;
    logic [COUNTER_WIDTH-1:0] ctr_new;
    logic [EXT_W-1:0]         ctr_ext;
    logic                     wr_en;
    logic [TBL_AW-1:0]        wr_addr;
    logic [COUNTER_WIDTH-1:0] wr_data;

    // Reduction constants: first pass by the index modulus, second by the table depth.
    assign modulus = mod_sel_reg ? REM_W'(TABLE_DEPTH) : REM_W'(INDEX_MODULUS);
    assign mu      = mod_sel_reg ? MU_TABLE : MU_INDEX;

    // The address digits are folded while the transaction is accepted.
    bbp_digit_reduce #(
        .MODULUS (INDEX_MODULUS),
        .SUM_W   (SUM_W)
    ) u_fold (
        .addr (s_tdata[ADDR_W-1:0]),
        .sum  (fold_sum)
    );

    // The estimate is the true quotient or one less, so one correction finishes it.
    assign quot_prod = PROD_W'(sum_reg) * PROD_W'(mu);
    assign quot_est  = mod_sel_reg ? quot_prod[MOD_AW +: MU_W] : quot_prod[SUM_W +: MU_W];
    assign quot_mul  = SUM_W'(quot_reg) * SUM_W'(modulus);
    assign diff_full = sum_reg - quot_mul;
    assign rem_fixed = (diff_reg >= modulus) ? diff_reg - modulus : diff_reg;
    assign tbl_idx   = rem_reg[TBL_AW-1:0];

    // Next values of the index unit.
    always_comb begin
        mod_sel_next = mod_sel_reg;
        sum_next     = sum_reg;
        if (cmd.load_item) begin
            mod_sel_next = 1'b0;
            sum_next     = fold_sum;
        end else if (cmd.wrap_load) begin
            mod_sel_next = 1'b1;
            sum_next     = SUM_W'(rem_fixed);
        end
    end

    // Saturating counter update toward the resolved outcome.
    always_comb begin
        ctr_new = rd_data_reg;
        if (taken_reg) begin
            if (rd_data_reg != CTR_MAX) begin
                ctr_new = rd_data_reg + 1'b1;
            end
        end else begin
            if (rd_data_reg != '0) begin
                ctr_new = rd_data_reg - 1'b1;
            end
        end
    end

    assign ctr_ext = EXT_W'(rd_data_reg);

    // Result register handshake.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_sel_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mod_sel_reg   <= mod_sel_next;
            out_valid_reg <= out_valid_next;
            if (cmd.clear_wr) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (cmd.load_item) begin
            cmd_reg   <= s_tuser[0];
            taken_reg <= s_tdata[ADDR_W];
        end
        if (cmd.quot_en) begin
            quot_reg <= quot_est;
        end
        if (cmd.sub_en) begin
            diff_reg <= REM_W'(diff_full);
        end
        if (cmd.fix_en) begin
            rem_reg <= rem_fixed;
        end
        if (cmd.finish) begin
            out_pred_reg <= rd_data_reg[COUNTER_WIDTH-1];
            out_ctr_reg  <= ctr_ext[CTR_OUT_W-1:0];
        end
    end

    // One write port shared by the clearing pass and the counter update.
    assign wr_en   = cmd.clear_wr || (cmd.finish && (cmd_reg == CMD_UPDATE));
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : tbl_idx;
    assign wr_data = cmd.clear_wr ? '0 : ctr_new;

    // Counter memory, one write and one registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[tbl_idx];
        end
    end

    assign status.clear_last = (clr_addr_reg == TBL_AW'(TABLE_DEPTH - 1));
    assign status.wrap_due   = NEED_FOLD && !mod_sel_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - CTR_OUT_W - 1){1'b0}}, out_ctr_reg, out_pred_reg};

endmodule

`default_nettype wire

/* rtl/core/bimodal_branch_predictor.sv */
// Top level of the bimodal branch predictor: joins controller and datapath.
// Depends on bbp_pkg, bbp_ctrl and bbp_datapath.
`default_nettype none

// Bimodal predictor with a table of TABLE_DEPTH saturating counters, indexed
// by the branch address modulo INDEX_MODULUS (and then modulo TABLE_DEPTH).
// Each transaction returns one result holding the counter before any change;
// an update transaction then moves the counter toward the resolved outcome.
// After reset the block clears the table, one entry per cycle, and accepts no
// transaction until that is done. One transaction occupies the block from its
// acceptance, in which the address digits are folded into a short sum, through
// the index remainder (quotient estimate, multiply and subtract, final
// correction) and the table read to the counter update. When INDEX_MODULUS
// exceeds TABLE_DEPTH, the wrap into the table repeats the remainder steps in
// the same unit. The result waits in an output register, so the next
// transaction can start while it is still pending on m_tready; that
// transaction's update cycle then stalls until the earlier result is taken.
module bimodal_branch_predictor
    import bbp_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int INDEX_MODULUS = DEF_INDEX_MODULUS,
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [63:0] branch_address, [64] outcome_taken, [71:65] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] cmd (0 predict, 1 update)
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] predict_taken, [2:1] counter_value, [7:3] zero
    output logic      [M_TDATA_W-1:0] m_tdata
);

    bbp_cmd_t    cmd;
    bbp_status_t status;

    // Sequencer.
    bbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Index unit, counter table and result register.
    bbp_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .INDEX_MODULUS (INDEX_MODULUS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

/* rtl/core/bbp_checker.sv */
// Port-level checker of the bimodal branch predictor, bound to the top level.
// Depends on bbp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bbp_checker
    import bbp_pkg::*;
#(
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A pending result holds its value until the transaction completes.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // Reset empties the result register and starts the clearing pass.
    `ASSERT_CLK_NORST(a_reset_state, aclk, !aresetn |=> !m_tvalid && !s_tready)

    // The block works on one transaction at a time.
    `ASSERT_CLK(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)

    // With two-bit counters the prediction is the counter's upper bit.
    `ASSERT_CLK(a_pred_msb, aclk, aresetn, (COUNTER_WIDTH == 2) && m_tvalid |-> m_tdata[0] == m_tdata[2])

endmodule

bind bimodal_branch_predictor bbp_checker #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
) u_bbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
